// ===== sv/stereo_level_meter_ballistics_top_defines.svh =====
// assertion macros for the stereo level meter ballistics block
// used by stereo_level_meter_ballistics_top.sv, no other dependencies
`ifndef STEREO_LEVEL_METER_BALLISTICS_TOP_DEFINES_SVH
`define STEREO_LEVEL_METER_BALLISTICS_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SLMB_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("slmb assertion failed");
`define SLMB_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("slmb assertion failed");
`else
`define SLMB_ASSERT(lbl, clk, rst_n, prop)
`define SLMB_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== sv/slmb_pkg.sv =====
// types and constants for the stereo level meter ballistics block
// no dependencies
`default_nettype none

package slmb_pkg;

  localparam int LVL_W   = 16;
  localparam int COEF_W  = 16;
  localparam int HOLD_W  = 8;
  localparam int FRAC_W  = 15;
  localparam int PROD_W  = COEF_W + LVL_W + 2;
  localparam int SUM_W   = PROD_W - FRAC_W + 1;
  localparam int CFG_AW  = 5;
  localparam int CFG_DW  = 32;
  localparam int IN_DW   = 2 * LVL_W;
  localparam int OUT_DW  = ((4 * LVL_W + 3 + 7) / 8) * 8;

  typedef enum logic [2:0] {
    REG_ATTACK  = 3'd0,
    REG_RELEASE = 3'd1,
    REG_HOLD    = 3'd2,
    REG_DECAY   = 3'd3,
    REG_CLIP    = 3'd4
  } reg_idx_t;

  localparam logic [COEF_W-1:0] ATTACK_RST  = COEF_W'(13107);
  localparam logic [COEF_W-1:0] RELEASE_RST = COEF_W'(3277);
  localparam logic [HOLD_W-1:0] HOLD_RST    = HOLD_W'(30);
  localparam logic [LVL_W-1:0]  DECAY_RST   = LVL_W'(164);
  localparam logic [LVL_W-1:0]  CLIP_RST    = LVL_W'(16384);

  typedef enum logic {
    ACT_TICK  = 1'b0,
    ACT_CLEAR = 1'b1
  } action_t;

  typedef struct packed {
    action_t            action;
    logic [LVL_W-1:0]   level_right;
    logic [LVL_W-1:0]   level_left;
  } item_t;

  typedef struct packed {
    logic [LVL_W-1:0]   smooth;
    logic [LVL_W-1:0]   peak;
    logic [HOLD_W-1:0]  hold;
    logic               clip;
  } chan_t;

  typedef struct packed {
    logic               active;
    logic               clip_right;
    logic               clip_left;
    logic [LVL_W-1:0]   peak_right;
    logic [LVL_W-1:0]   peak_left;
    logic [LVL_W-1:0]   smooth_right;
    logic [LVL_W-1:0]   smooth_left;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/stereo_level_meter_ballistics_top.sv =====
// stereo level meter ballistics: smoothing, peak hold and clip latch per channel
// depends on slmb_pkg and stereo_level_meter_ballistics_top_defines.svh
// path: each item is held in the input register, then its result is registered into the result register,
// which drives out_tvalid; one item per cycle while out_tready does not stall the output, with the
// multiply-add per channel done combinationally between the input register and the result register
// rst_n (synchronous) clears meter state and clip latches, loads register defaults
`default_nettype none
`include "stereo_level_meter_ballistics_top_defines.svh"

module stereo_level_meter_ballistics_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // in_tdata: level_left [15:0], level_right [31:16]
  input  wire logic [slmb_pkg::IN_DW-1:0]  in_tdata,
  // in_tuser: action [0]
  input  wire logic                        in_tuser,
  input  wire logic                        in_tvalid,
  output      logic                        in_tready,
  // out_tdata: smooth_left, smooth_right, peak_left, peak_right,
  // clip_left, clip_right, active, zero pad
  output      logic [slmb_pkg::OUT_DW-1:0] out_tdata,
  output      logic                        out_tvalid,
  input  wire logic                        out_tready,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [slmb_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [slmb_pkg::CFG_DW-1:0] cfg_pwdata,
  output      logic [slmb_pkg::CFG_DW-1:0] cfg_prdata,
  output      logic                        cfg_pready
);
  import slmb_pkg::*;

  logic [COEF_W-1:0] attack_r;
  logic [COEF_W-1:0] release_r;
  logic [HOLD_W-1:0] hold_ticks_r;
  logic [LVL_W-1:0]  decay_r;
  logic [LVL_W-1:0]  clip_lvl_r;

  logic              in_valid_r;
  item_t             in_item_r;
  logic              out_valid_r;
  result_t           out_res_r;
  result_t           res_nxt;
  chan_t             chl_r, chr_r, chl_nxt, chr_nxt;
  logic              advance;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  function automatic logic [LVL_W-1:0] smooth_step(input logic [LVL_W-1:0] cur,
                                                   input logic [LVL_W-1:0] raw,
                                                   input logic [COEF_W-1:0] k);
    logic signed [LVL_W:0]    diff;
    logic signed [COEF_W:0]   ks;
    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0]  sum;
    logic [LVL_W-1:0]         res;
    diff = $signed({1'b0, raw}) - $signed({1'b0, cur});
    ks   = $signed({1'b0, k});
    prod = PROD_W'(ks) * PROD_W'(diff);
    sum  = SUM_W'($signed({1'b0, cur})) + SUM_W'(prod >>> FRAC_W);
    if (sum[SUM_W-1]) begin
      res = '0;
    end else if (|sum[SUM_W-2:LVL_W]) begin
      res = '1;
    end else begin
      res = sum[LVL_W-1:0];
    end
    return res;
  endfunction

  function automatic chan_t chan_step(input chan_t cur, input logic [LVL_W-1:0] raw,
                                      input logic [COEF_W-1:0] ka,
                                      input logic [COEF_W-1:0] kr,
                                      input logic [HOLD_W-1:0] hold_ticks,
                                      input logic [LVL_W-1:0] decay,
                                      input logic [LVL_W-1:0] clip_lvl);
    chan_t nxt;
    nxt        = cur;
    nxt.smooth = smooth_step(cur.smooth, raw, (raw > cur.smooth) ? ka : kr);
    if (nxt.smooth >= cur.peak) begin
      nxt.peak = nxt.smooth;
      nxt.hold = hold_ticks;
    end else if (cur.hold != '0) begin
      nxt.hold = cur.hold - HOLD_W'(1);
    end else begin
      nxt.peak = (cur.peak > decay) ? (cur.peak - decay) : '0;
    end
    if (raw > clip_lvl) begin
      nxt.clip = 1'b1;
    end
    return nxt;
  endfunction

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[CFG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r     <= ATTACK_RST;
      release_r    <= RELEASE_RST;
      hold_ticks_r <= HOLD_RST;
      decay_r      <= DECAY_RST;
      clip_lvl_r   <= CLIP_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ATTACK:  attack_r     <= cfg_pwdata[COEF_W-1:0];
        REG_RELEASE: release_r    <= cfg_pwdata[COEF_W-1:0];
        REG_HOLD:    hold_ticks_r <= cfg_pwdata[HOLD_W-1:0];
        REG_DECAY:   decay_r      <= cfg_pwdata[LVL_W-1:0];
        REG_CLIP:    clip_lvl_r   <= cfg_pwdata[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ATTACK:  cfg_prdata = CFG_DW'(attack_r);
      REG_RELEASE: cfg_prdata = CFG_DW'(release_r);
      REG_HOLD:    cfg_prdata = CFG_DW'(hold_ticks_r);
      REG_DECAY:   cfg_prdata = CFG_DW'(decay_r);
      REG_CLIP:    cfg_prdata = CFG_DW'(clip_lvl_r);
      default:     cfg_prdata = '0;
    endcase
  end

  // stream handshake
  assign advance    = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !in_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'(out_res_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r <= item_t'({in_tuser, in_tdata});
    end
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  // per-item update
  always_comb begin
    chl_nxt = chl_r;
    chr_nxt = chr_r;
    if (in_item_r.action == ACT_CLEAR) begin
      chl_nxt.clip = 1'b0;
      chr_nxt.clip = 1'b0;
    end else begin
      chl_nxt = chan_step(chl_r, in_item_r.level_left, attack_r, release_r,
                          hold_ticks_r, decay_r, clip_lvl_r);
      chr_nxt = chan_step(chr_r, in_item_r.level_right, attack_r, release_r,
                          hold_ticks_r, decay_r, clip_lvl_r);
    end
    res_nxt.smooth_left  = chl_nxt.smooth;
    res_nxt.smooth_right = chr_nxt.smooth;
    res_nxt.peak_left    = chl_nxt.peak;
    res_nxt.peak_right   = chr_nxt.peak;
    res_nxt.clip_left    = chl_nxt.clip;
    res_nxt.clip_right   = chr_nxt.clip;
    res_nxt.active       = (in_item_r.action == ACT_CLEAR) ||
                           (chl_nxt.smooth != '0) || (chr_nxt.smooth != '0) ||
                           (chl_nxt.peak != '0) || (chr_nxt.peak != '0) ||
                           chl_nxt.clip || chr_nxt.clip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chl_r <= '0;
      chr_r <= '0;
    end else if (advance) begin
      chl_r <= chl_nxt;
      chr_r <= chr_nxt;
    end
  end

  `SLMB_ASSERT(a_clip_means_active, clk, rst_n,
    out_valid_r && (out_res_r.clip_left || out_res_r.clip_right) |-> out_res_r.active)
  `SLMB_ASSERT(a_empty_stage_ready, clk, rst_n, !in_valid_r |-> in_tready)
  `SLMB_ASSERT(a_state_only_on_advance, clk, rst_n,
    !advance |=> $stable(chl_r) && $stable(chr_r))
  `SLMB_ASSERT(a_advance_fills_output, clk, rst_n, advance |=> out_valid_r)
  `SLMB_ASSERT_ALWAYS(a_pready_high, clk, cfg_pready)

endmodule

`default_nettype wire

// ===== tb/sv/tb_stereo_level_meter_ballistics_top.sv =====
// testbench for stereo_level_meter_ballistics_top: directed and random meter ticks and
// clip clears under random stalls, checked against a cycle-free ballistics predictor
// depends on slmb_pkg and the rtl of stereo_level_meter_ballistics_top

module tb_stereo_level_meter_ballistics_top;
  import slmb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_OFF_CYCLES = 300;

  class level_meter_check;
    logic [15:0] attack_k;
    logic [15:0] release_k;
    logic [7:0]  hold_len;
    logic [15:0] decay_amt;
    logic [15:0] clip_lvl;
    logic [15:0] smooth_lvl[2];
    logic [15:0] peak_lvl[2];
    logic [7:0]  hold_cnt[2];
    logic        clip_flag[2];
    result_t     expected_readings[$];
    int          errors;

    function new();
      attack_k  = ATTACK_RST;
      release_k = RELEASE_RST;
      hold_len  = HOLD_RST;
      decay_amt = DECAY_RST;
      clip_lvl  = CLIP_RST;
      for (int i = 0; i < 2; i++) begin
        smooth_lvl[i] = '0;
        peak_lvl[i]   = '0;
        hold_cnt[i]   = '0;
        clip_flag[i]  = 1'b0;
      end
      errors = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] v);
      case (idx)
        REG_ATTACK:  attack_k  = v[15:0];
        REG_RELEASE: release_k = v[15:0];
        REG_HOLD:    hold_len  = v[7:0];
        REG_DECAY:   decay_amt = v[15:0];
        REG_CLIP:    clip_lvl  = v[15:0];
        default: ;
      endcase
    endfunction

    function logic [15:0] smooth_next(logic [15:0] cur, logic [15:0] raw);
      longint k;
      longint v;
      k = (raw > cur) ? longint'(attack_k) : longint'(release_k);
      // arithmetic shift floors the signed product
      v = longint'(cur) + ((k * (longint'(raw) - longint'(cur))) >>> 15);
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return v[15:0];
    endfunction

    function void peak_next(int i);
      if (smooth_lvl[i] >= peak_lvl[i]) begin
        peak_lvl[i] = smooth_lvl[i];
        hold_cnt[i] = hold_len;
      end else if (hold_cnt[i] != 0) begin
        hold_cnt[i] = hold_cnt[i] - 8'd1;
      end else begin
        peak_lvl[i] = (peak_lvl[i] > decay_amt) ? peak_lvl[i] - decay_amt : 16'd0;
      end
    endfunction

    function void note_item(item_t it);
      result_t e;
      logic [15:0] raw[2];
      logic act;
      raw[0] = it.level_left;
      raw[1] = it.level_right;
      if (it.action == ACT_CLEAR) begin
        clip_flag[0] = 1'b0;
        clip_flag[1] = 1'b0;
        act = 1'b1;
      end else begin
        for (int i = 0; i < 2; i++) begin
          smooth_lvl[i] = smooth_next(smooth_lvl[i], raw[i]);
          peak_next(i);
          if (raw[i] > clip_lvl) clip_flag[i] = 1'b1;
        end
        act = (smooth_lvl[0] != 0) || (smooth_lvl[1] != 0) || (peak_lvl[0] != 0) ||
              (peak_lvl[1] != 0) || clip_flag[0] || clip_flag[1];
      end
      e.smooth_left  = smooth_lvl[0];
      e.smooth_right = smooth_lvl[1];
      e.peak_left    = peak_lvl[0];
      e.peak_right   = peak_lvl[1];
      e.clip_left    = clip_flag[0];
      e.clip_right   = clip_flag[1];
      e.active       = act;
      expected_readings.push_back(e);
    endfunction

    function void cmp(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_reading(result_t got);
      result_t e;
      if (expected_readings.size() == 0) begin
        $error("result transfer with no expected reading: %h", got);
        errors++;
        return;
      end
      e = expected_readings.pop_front();
      cmp("smooth_left", e.smooth_left, got.smooth_left);
      cmp("smooth_right", e.smooth_right, got.smooth_right);
      cmp("peak_left", e.peak_left, got.peak_left);
      cmp("peak_right", e.peak_right, got.peak_right);
      cmp("clip_left", 16'(e.clip_left), 16'(got.clip_left));
      cmp("clip_right", 16'(e.clip_right), 16'(got.clip_right));
      cmp("active", 16'(e.active), 16'(got.active));
    endfunction

    function int outstanding();
      return expected_readings.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic [IN_DW-1:0]    in_tdata;
  logic                in_tuser;
  logic                in_tvalid;
  logic                in_tready;
  logic [OUT_DW-1:0]   out_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CFG_AW-1:0]   cfg_paddr;
  logic [CFG_DW-1:0]   cfg_pwdata;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  level_meter_check sb;
  bit               burst;
  bit               long_hold_req;
  bit               holding;
  int unsigned      cycles;
  logic [15:0]      prev_left;
  logic [15:0]      prev_right;

  stereo_level_meter_ballistics_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pick_level(logic [15:0] prev, logic [15:0] clip);
    int v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = 65535;
      2: v = int'(prev);
      3: v = int'(clip) + $urandom_range(0, 2) - 1;
      4: v = $urandom_range(0, 255);
      5, 6: v = $urandom_range(0, 20000);
      default: v = $urandom_range(0, 65535);
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  always @(posedge clk) begin
    item_t it;
    if (rst_n && in_tvalid && in_tready) begin
      it.action      = action_t'(in_tuser);
      it.level_left  = in_tdata[15:0];
      it.level_right = in_tdata[31:16];
      sb.note_item(it);
    end
    if (rst_n && out_tvalid && out_tready)
      sb.check_reading(result_t'(out_tdata[$bits(result_t)-1:0]));
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int n;
    int g;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold_req) begin
        holding = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        long_hold_req = 1'b0;
        holding = 1'b0;
      end else begin
        out_tready <= 1'b1;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
        repeat (n) @(posedge clk);
        g = pick_gap();
        if (g > 0) begin
          out_tready <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
    end
  end

  task automatic send_item(action_t act, logic [15:0] l, logic [15:0] r);
    int gap;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {r, l};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain(int limit);
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    // let the monitor note the last input transfer first
    @(posedge clk);
    while (sb.outstanding() != 0 && waited < limit) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'({idx, 2'b00});
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  task automatic set_config(int atk, int rel, int hold, int decay, int clip);
    drain(20000);
    write_reg(REG_ATTACK, atk);
    write_reg(REG_RELEASE, rel);
    write_reg(REG_HOLD, hold);
    write_reg(REG_DECAY, decay);
    write_reg(REG_CLIP, clip);
  endtask

  task automatic random_config();
    set_config($urandom_range(0, 32768), $urandom_range(0, 32768),
               $urandom_range(0, 1) ? $urandom_range(0, 12) : $urandom_range(0, 255),
               $urandom_range(0, 1) ? $urandom_range(0, 2000) : $urandom_range(0, 65535),
               $urandom_range(0, 65535));
  endtask

  task automatic run_random(int n);
    int silence;
    action_t act;
    logic [15:0] l;
    logic [15:0] r;
    silence = 0;
    for (int i = 0; i < n; i++) begin
      if (silence > 0) begin
        silence--;
        act = ACT_TICK;
        l = '0;
        r = '0;
      end else begin
        if ($urandom_range(0, 99) < 5) silence = $urandom_range(4, 50);
        act = ($urandom_range(0, 99) < 7) ? ACT_CLEAR : ACT_TICK;
        l = pick_level(prev_left, sb.clip_lvl);
        r = pick_level(prev_right, sb.clip_lvl);
      end
      send_item(act, l, r);
      prev_left = l;
      prev_right = r;
    end
  endtask

  initial begin
    sb = new();
    cycles = 0;
    burst = 1'b0;
    long_hold_req = 1'b0;
    holding = 1'b0;
    prev_left = '0;
    prev_right = '0;
    rst_n = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tvalid = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: silence, full scale, clip boundary, clears, ties and release
    send_item(ACT_TICK, 16'd0, 16'd0);
    send_item(ACT_TICK, 16'd65535, 16'd0);
    send_item(ACT_TICK, 16'd65535, 16'd65535);
    send_item(ACT_TICK, 16'd65535, 16'd65535);
    send_item(ACT_TICK, 16'd16384, 16'd16385);
    send_item(ACT_TICK, 16'd16385, 16'd16384);
    send_item(ACT_CLEAR, 16'd12345, 16'd54321);
    repeat (3) send_item(ACT_TICK, 16'd0, 16'd0);
    send_item(ACT_CLEAR, 16'd0, 16'd0);
    send_item(ACT_CLEAR, 16'd65535, 16'd65535);
    send_item(ACT_TICK, 16'd30000, 16'd30000);
    send_item(ACT_TICK, 16'd30000, 16'd30000);
    send_item(ACT_TICK, 16'd1, 16'd65535);
    repeat (3) send_item(ACT_TICK, 16'd0, 16'd0);

    set_config(32768, 32768, 0, 65535, 0);
    run_random(120);
    set_config(0, 0, 255, 0, 65535);
    run_random(60);
    set_config(1, 32767, 1, 1, 16384);
    run_random(100);

    random_config();
    run_random(40);
    in_tvalid <= 1'b0;
    long_hold_req = 1'b1;
    while (!holding) @(posedge clk);
    burst = 1'b1;
    run_random(40);
    burst = 1'b0;
    drain(20000);
    run_random(30);
    random_config();
    run_random(110);
    random_config();
    run_random(110);

    set_config(int'(ATTACK_RST), int'(RELEASE_RST), int'(HOLD_RST), int'(DECAY_RST),
               int'(CLIP_RST));
    run_random(100);

    drain(20000);
    repeat (10) @(posedge clk);
    if (sb.outstanding() != 0) begin
      $error("%0d expected readings never arrived", sb.outstanding());
      sb.errors++;
    end
    if (sb.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/slmb_pkg.sv
sv/stereo_level_meter_ballistics_top.sv
tb/sv/tb_stereo_level_meter_ballistics_top.sv
